/* rtl/spds_pkg.sv */
// shared types, constants and a helper function for the sample pair difference statistics block
`default_nettype none
package spds_pkg;
  localparam int unsigned CountWidthDef = 40;
  localparam int unsigned RatioFracDef = 20;
  localparam int unsigned BinTotal = 11;
  localparam int unsigned CutTotal = 10;
  localparam int unsigned KindLast = 15;
  localparam logic [63:0] ValueMax = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [2:0] {
    StIdle,
    StDivide,
    StUpdate,
    StReport
  } spds_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic update;
    logic rep_start;
    logic rep_next;
  } spds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic rep_last;
    logic out_full;
  } spds_sts_t;

  // clamp a wide value to the 32-bit ratio format
  function automatic logic [31:0] sat32(input logic [63:0] v);
    begin
      sat32 = (v > ValueMax) ? 32'hFFFF_FFFF : v[31:0];
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/spds_ctrl.sv */
// controller state machine: divide, update and report sequencing
`default_nettype none
module spds_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             action_i,
  output logic                  in_ready_o,
  input  wire spds_pkg::spds_sts_t sts_i,
  output spds_pkg::spds_cmd_t   cmd_o
);
  import spds_pkg::*;

  spds_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i) begin
            cmd_o.rep_start = 1'b1;
            state_d = StReport;
          end else begin
            cmd_o.load = 1'b1;
            state_d = StDivide;
          end
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d = StIdle;
      end
      StReport: begin
        if (!sts_i.out_full) begin
          cmd_o.rep_next = 1'b1;
          if (sts_i.rep_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/spds_dp.sv */
// datapath: difference, serial divider, statistics store and report output register
`default_nettype none
module spds_dp #(
  parameter int unsigned COUNT_WIDTH = spds_pkg::CountWidthDef,
  parameter int unsigned RATIO_FRACTION_BITS = spds_pkg::RatioFracDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic signed [31:0]     reference_sample_i,
  input  wire logic signed [31:0]     candidate_sample_i,
  input  wire spds_pkg::spds_cmd_t    cmd_i,
  output spds_pkg::spds_sts_t         sts_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [3:0]                  statistic_kind_o,
  output logic [63:0]                 statistic_value_o,
  output logic [39:0]                 statistic_position_o,
  output logic                        position_found_o,
  output logic                        report_last_o
);
  import spds_pkg::*;

  localparam int unsigned F = RATIO_FRACTION_BITS;
  localparam int unsigned DivBits = 33 + F;  // dividend width
  localparam int unsigned CntW = $clog2(DivBits + 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  // histogram cutoffs rounded to nearest in the ratio format
  localparam logic [31:0] Cut0 = sat32(((64'd1 << F) + 64'd5000) / 64'd10000);
  localparam logic [31:0] Cut1 = sat32(((64'd1 << F) + 64'd500) / 64'd1000);
  localparam logic [31:0] Cut2 = sat32(((64'd1 << F) + 64'd50) / 64'd100);
  localparam logic [31:0] Cut3 = sat32(((64'd1 << F) + 64'd5) / 64'd10);
  localparam logic [31:0] Cut4 = sat32(((64'd3 << F) + 64'd5) / 64'd10);
  localparam logic [31:0] Cut5 = sat32(64'd1 << F);
  localparam logic [31:0] Cut6 = sat32(64'd3 << F);
  localparam logic [31:0] Cut7 = sat32(64'd10 << F);
  localparam logic [31:0] Cut8 = sat32(64'd100 << F);
  localparam logic [31:0] Cut9 = sat32(64'd1000 << F);
  localparam logic [CutTotal-1:0][31:0] Cut =
    {Cut9, Cut8, Cut7, Cut6, Cut5, Cut4, Cut3, Cut2, Cut1, Cut0};

  // operand registers
  logic [32:0]        mag_q, mag_d;
  logic [32:0]        rmag_q;
  logic [DivBits-1:0] rem_q;      // shifting dividend / quotient
  logic [33:0]        part_q;     // partial remainder
  logic [CntW-1:0]    cnt_q;

  logic signed [32:0] diff_s;
  logic [32:0]        rmag_d;
  assign diff_s = 33'(candidate_sample_i) - 33'(reference_sample_i);
  assign mag_d  = diff_s[32] ? 33'(-diff_s) : 33'(diff_s);
  assign rmag_d = reference_sample_i[31] ? 33'(-33'(reference_sample_i))
                                         : 33'(reference_sample_i);

  // one restoring division step per cycle
  logic [33:0] trial;
  logic [33:0] shifted;
  assign shifted = {part_q[32:0], rem_q[DivBits-1]};
  assign trial   = shifted - {1'b0, rmag_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q  <= mag_d;
      rmag_q <= rmag_d;
      rem_q  <= {mag_d, F'(0)};
      part_q <= '0;
      cnt_q  <= CntW'(DivBits);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      if (!trial[33]) begin
        part_q <= trial;
        rem_q  <= {rem_q[DivBits-2:0], 1'b1};
      end else begin
        part_q <= shifted;
        rem_q  <= {rem_q[DivBits-2:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (cnt_q == '0);

  // saturated results
  logic [31:0] diffq, ratio;
  logic [32+F-8:0] diff_wide;
  assign diff_wide = {mag_q, (F-8)'(0)};
  assign diffq = (diff_wide[32+F-8:32] != '0) ? 32'hFFFF_FFFF : diff_wide[31:0];
  assign ratio = (rmag_q == '0) ? 32'hFFFF_FFFF :
                 (rem_q[DivBits-1:32] != '0) ? 32'hFFFF_FFFF : rem_q[31:0];

  // bin select
  logic [BinTotal-1:0] below;
  logic [3:0] bin;
  always_comb begin
    for (int k = 0; k < CutTotal; k++) begin
      below[k] = ratio < Cut[k];
    end
    below[CutTotal] = 1'b1;
    bin = 4'(CutTotal);
    for (int k = CutTotal - 1; k >= 0; k--) begin
      if (below[k]) bin = 4'(k);
    end
  end

  // statistics store
  logic [31:0]            ldiff_q, lratio_q;
  logic [COUNT_WIDTH-1:0] ldiff_pos_q, lratio_pos_q, count_q;
  logic                   ldiff_seen_q, lratio_seen_q;
  logic [63:0]            dsum_q, rsum_q;
  logic [COUNT_WIDTH-1:0] bins_q [BinTotal];
  logic [64:0]            dsum_d, rsum_d;
  assign dsum_d = {1'b0, dsum_q} + 65'(diffq);
  assign rsum_d = {1'b0, rsum_q} + 65'(ratio);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldiff_q <= '0; lratio_q <= '0;
      ldiff_pos_q <= '0; lratio_pos_q <= '0; count_q <= '0;
      ldiff_seen_q <= 1'b0; lratio_seen_q <= 1'b0;
      dsum_q <= '0; rsum_q <= '0;
      for (int k = 0; k < BinTotal; k++) bins_q[k] <= '0;
    end else if (cmd_i.update) begin
      if (diffq > ldiff_q) begin
        ldiff_q <= diffq; ldiff_pos_q <= count_q; ldiff_seen_q <= 1'b1;
      end
      if (ratio > lratio_q) begin
        lratio_q <= ratio; lratio_pos_q <= count_q; lratio_seen_q <= 1'b1;
      end
      dsum_q <= dsum_d[64] ? '1 : dsum_d[63:0];
      rsum_q <= rsum_d[64] ? '1 : rsum_d[63:0];
      if (bins_q[bin] != CountMax) bins_q[bin] <= bins_q[bin] + 1'b1;
      if (count_q != CountMax) count_q <= count_q + 1'b1;
    end
  end

  // report sequencer and output register
  logic [3:0]  kind_q;
  logic        ovalid_q;
  logic [63:0] val_sel;
  logic [39:0] pos_sel;
  logic        fnd_sel;

  always_comb begin
    val_sel = '0; pos_sel = '0; fnd_sel = 1'b0;
    unique case (kind_q)
      4'd0: begin val_sel = 64'(ldiff_q); pos_sel = 40'(ldiff_pos_q); fnd_sel = ldiff_seen_q; end
      4'd1: begin
        val_sel = 64'(lratio_q); pos_sel = 40'(lratio_pos_q); fnd_sel = lratio_seen_q;
      end
      4'd2: val_sel = dsum_q;
      4'd3: val_sel = rsum_q;
      4'd4: val_sel = 64'(count_q);
      default: val_sel = 64'(bins_q[kind_q - 4'd5]);
    endcase
  end

  assign sts_o.out_full = ovalid_q && !out_ready_i;
  assign sts_o.rep_last = (kind_q == 4'(KindLast));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      kind_q <= '0;
    end else begin
      if (cmd_i.rep_start) kind_q <= '0;
      if (cmd_i.rep_next) begin
        ovalid_q <= 1'b1;
        kind_q <= kind_q + 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rep_next) begin
      statistic_kind_o     <= kind_q;
      statistic_value_o    <= val_sel;
      statistic_position_o <= pos_sel;
      position_found_o     <= fnd_sel;
      report_last_o        <= (kind_q == 4'(KindLast));
    end
  end
  assign out_valid_o = ovalid_q;

  // a maximum's seen bit is set exactly when its value is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni) ldiff_seen_q == (ldiff_q != '0))
    else $error("difference seen bit mismatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni) lratio_seen_q == (lratio_q != '0))
    else $error("ratio seen bit mismatch");
  // report never advances over an untaken word
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.rep_next |-> !sts_o.out_full)
    else $error("report word overwritten");
endmodule
`default_nettype wire

/* rtl/sample_pair_difference_statistics.sv */
// top level of the sample pair difference statistics block
// accumulate word: the word is accepted, then 33+RATIO_FRACTION_BITS divider steps (one quotient bit a cycle
// in the restoring divider), then the controller sees the step count run out and updates the statistics
// report word: sixteen result words, one per cycle while the output is taken, then ready again
// reset clears all statistics, the controller and the output valid at once
`default_nettype none
module sample_pair_difference_statistics #(
  parameter int unsigned COUNT_WIDTH = spds_pkg::CountWidthDef,
  parameter int unsigned RATIO_FRACTION_BITS = spds_pkg::RatioFracDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic signed [31:0] reference_sample_i,
  input  wire logic signed [31:0] candidate_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              statistic_kind_o,
  output logic [63:0]             statistic_value_o,
  output logic [39:0]             statistic_position_o,
  output logic                    position_found_o,
  output logic                    report_last_o
);
  import spds_pkg::*;

  // command and status between controller and datapath
  spds_cmd_t cmd;
  spds_sts_t sts;

  // the input is not taken again until the report's last word is in the output register
  spds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds the divider, the store and the output register
  spds_dp #(
    .COUNT_WIDTH         (COUNT_WIDTH),
    .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .reference_sample_i   (reference_sample_i),
    .candidate_sample_i   (candidate_sample_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .statistic_kind_o     (statistic_kind_o),
    .statistic_value_o    (statistic_value_o),
    .statistic_position_o (statistic_position_o),
    .position_found_o     (position_found_o),
    .report_last_o        (report_last_o)
  );

  // a new word is only taken while the controller is idle, and a taken word drops the ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice");
  // output carries a last marker only on the final kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (report_last_o == (statistic_kind_o == 4'(KindLast))))
    else $error("last marker mismatch");
  // controller never commands update and report together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd.update && cmd.rep_next))
    else $error("conflicting commands");
endmodule
`default_nettype wire
